### hdl/trbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbq_pkg
// Shared types and constants for the timed ring buffer with nearest query.
// ----------------------------------------------------------------------------
package trbq_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [5:0]  OUT_LIMIT      = 6'd32;
    localparam logic [31:0] DEFAULT_WINDOW = 32'd350000;
    localparam logic [5:0]  DEFAULT_CAP    = 6'd32;

    localparam logic [1:0] CMD_PUSH     = 2'd0;
    localparam logic [1:0] CMD_QTIME    = 2'd1;
    localparam logic [1:0] CMD_QVOICE   = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_ENTRY   = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_CAP    = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] time_us;
        logic [31:0] voice;
        logic [63:0] payload;
        logic [31:0] lookback_us;
        logic [31:0] lookahead_us;
        logic [5:0]  max_out;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] entry_time_us;
        logic [31:0] entry_voice;
        logic [63:0] entry_payload;
        logic        overwrote;
        logic [5:0]  pruned_count;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [63:0] time_us;
        logic [31:0] voice;
        logic [63:0] payload;
    } slot_t;

    typedef struct packed {
        logic [63:0]      gap;
        logic [IDX_W-1:0] idx;
    } cand_t;

    typedef struct packed {
        logic clr;
        logic ins;
        logic shl;
    } cell_ctl_t;

endpackage

### hdl/timed_ring_buffer_nearest_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_ring_buffer_nearest_query
// Ring store of timed entries with pruning push and nearest-in-time query.
// ----------------------------------------------------------------------------
// Push: reads and checks the oldest entry, pruning it while it lies beyond the window, then writes and acks.
// Query: the scan reads, then scores each stored entry into the sorted chain; results then alternate a read
// of the nearest candidate with its output, waiting while a result is pending; a max_out of 0 answers none.
// One item in work at a time, input stalled until done.
// Reset clears pointers and fill count, restores config defaults; slot contents undefined.
module timed_ring_buffer_nearest_query (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  trbq_pkg::in_t   in_item,
    output logic            out_valid,
    input  logic            out_stall,
    output trbq_pkg::out_t  out_item,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);

    localparam int IW = trbq_pkg::IDX_W;
    localparam int CW = trbq_pkg::CNT_W;
    localparam int N  = trbq_pkg::SLOTS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_PCHK = 3'd2;
    localparam logic [2:0] S_PWR  = 3'd3;
    localparam logic [2:0] S_QRD  = 3'd4;
    localparam logic [2:0] S_QCHK = 3'd5;
    localparam logic [2:0] S_QORD = 3'd6;
    localparam logic [2:0] S_QOUT = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      window_reg, window_next;
    logic [5:0]       cap_reg, cap_next;
    logic [IW-1:0]    oldest_reg, oldest_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [IW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    emit_reg, emit_next;
    logic [5:0]       pruned_reg, pruned_next;
    logic [5:0]       maxo_reg, maxo_next;
    logic             cok_reg, cok_next;
    trbq_pkg::cand_t  ccand_reg, ccand_next;
    trbq_pkg::in_t    req_reg, req_next;
    logic [63:0]      tmin_reg, tmin_next;
    logic [63:0]      tmax_reg, tmax_next;
    logic             out_valid_reg, out_valid_next;
    trbq_pkg::out_t   out_reg, out_next;

    logic [CW-1:0]    cap_eff;
    logic [31:0]      win_eff;
    logic [IW-1:0]    oldest_inc, ptr_inc;
    logic [CW-1:0]    app_sum;
    logic [IW-1:0]    app_slot;
    logic [64:0]      ahead_sum;
    logic [5:0]       maxo_clip;
    logic [CW-1:0]    take;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    trbq_pkg::slot_t  ram_wdata, ram_rdata;

    trbq_pkg::cell_ctl_t ctl;
    trbq_pkg::cand_t     cell_cand [N];
    logic [N-1:0]        cell_valid, cell_keep;

    always_comb
    begin
        if (cap_reg == 6'd0)
            cap_eff = CW'(1);
        else if (CW'(cap_reg) > trbq_pkg::SLOTS_CNT)
            cap_eff = trbq_pkg::SLOTS_CNT;
        else
            cap_eff = CW'(cap_reg);
    end

    assign win_eff    = (window_reg == 32'd0) ? trbq_pkg::DEFAULT_WINDOW : window_reg;
    assign oldest_inc = ((CW'(oldest_reg) + CW'(1)) == cap_eff) ? '0 : oldest_reg + IW'(1);
    assign ptr_inc    = ((CW'(ptr_reg) + CW'(1)) == cap_eff) ? '0 : ptr_reg + IW'(1);
    assign app_sum    = CW'(oldest_reg) + fill_reg;
    assign app_slot   = (app_sum >= cap_eff) ? IW'(app_sum - cap_eff) : IW'(app_sum);
    assign ahead_sum  = {1'b0, in_item.time_us} + 65'(in_item.lookahead_us);
    assign maxo_clip  = (in_item.max_out > trbq_pkg::OUT_LIMIT) ? trbq_pkg::OUT_LIMIT
                                                                 : in_item.max_out;
    assign take       = (n_reg < CW'(maxo_reg)) ? n_reg : CW'(maxo_reg);

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    trbq_ram #(
        .WIDTH ($bits(trbq_pkg::slot_t)),
        .DEPTH (N)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        trbq_pkg::cand_t lc, rc;
        logic            lk, lv, rv;
        if (k == 0)
        begin : g_head
            assign lk = 1'b1;
            assign lc = ccand_reg;
            assign lv = 1'b1;
        end
        else
        begin : g_body
            assign lk = cell_keep[k-1];
            assign lc = cell_cand[k-1];
            assign lv = cell_valid[k-1];
        end
        if (k == N - 1)
        begin : g_tail
            assign rc = cell_cand[k];
            assign rv = 1'b0;
        end
        else
        begin : g_mid
            assign rc = cell_cand[k+1];
            assign rv = cell_valid[k+1];
        end
        trbq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_cand    (ccand_reg),
            .left_keep   (lk),
            .left_cand   (lc),
            .left_valid  (lv),
            .right_cand  (rc),
            .right_valid (rv),
            .cand        (cell_cand[k]),
            .valid       (cell_valid[k]),
            .keep        (cell_keep[k])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        cap_next       = cap_reg;
        oldest_next    = oldest_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        scan_next      = scan_reg;
        n_next         = n_reg;
        emit_next      = emit_reg;
        pruned_next    = pruned_reg;
        maxo_next      = maxo_reg;
        cok_next       = cok_reg;
        ccand_next     = ccand_reg;
        req_next       = req_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = app_slot;
        ram_wdata      = '{time_us: req_reg.time_us, voice: req_reg.voice,
                           payload: req_reg.payload};
        ram_raddr      = oldest_reg;
        ctl            = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                trbq_pkg::REG_WINDOW: window_next = cfg_data;
                trbq_pkg::REG_CAP:
                begin
                    cap_next    = cfg_data[5:0];
                    oldest_next = '0;
                    fill_next   = '0;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next    = in_item;
                    pruned_next = '0;
                    maxo_next   = maxo_clip;
                    tmin_next   = (in_item.time_us > 64'(in_item.lookback_us))
                                  ? in_item.time_us - 64'(in_item.lookback_us) : 64'd0;
                    tmax_next   = ahead_sum[64] ? '1 : ahead_sum[63:0];
                    ptr_next    = oldest_reg;
                    scan_next   = '0;
                    n_next      = '0;
                    emit_next   = '0;
                    cok_next    = 1'b0;
                    if (in_item.cmd == trbq_pkg::CMD_PUSH)
                    begin
                        state_next = S_PRD;
                    end
                    else if (in_item.cmd == trbq_pkg::CMD_QTIME ||
                             in_item.cmd == trbq_pkg::CMD_QVOICE)
                    begin
                        ctl.clr    = 1'b1;
                        state_next = (maxo_clip == 6'd0) ? S_QORD : S_QRD;
                    end
                end
            end
            S_PRD:
            begin
                ram_raddr  = oldest_reg;
                state_next = (fill_reg == '0) ? S_PWR : S_PCHK;
            end
            S_PCHK:
            begin
                if (req_reg.time_us >= ram_rdata.time_us &&
                    (req_reg.time_us - ram_rdata.time_us) > 64'(win_eff))
                begin
                    oldest_next = oldest_inc;
                    fill_next   = fill_reg - CW'(1);
                    pruned_next = pruned_reg + 6'd1;
                    state_next  = S_PRD;
                end
                else
                begin
                    state_next = S_PWR;
                end
            end
            S_PWR:
            begin
                ram_we = 1'b1;
                out_next = '0;
                out_next.kind = trbq_pkg::KIND_ACK;
                out_next.pruned_count = pruned_reg;
                out_next.last = 1'b1;
                if (fill_reg < cap_eff)
                begin
                    ram_waddr = app_slot;
                    fill_next = fill_reg + CW'(1);
                end
                else
                begin
                    ram_waddr   = oldest_reg;
                    oldest_next = oldest_inc;
                    out_next.overwrote = 1'b1;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_QRD:
            begin
                // insert the candidate scored in the previous step
                ctl.ins   = cok_reg;
                n_next    = n_reg + CW'(cok_reg);
                cok_next  = 1'b0;
                ram_raddr = ptr_reg;
                state_next = (scan_reg == fill_reg) ? S_QORD : S_QCHK;
            end
            S_QCHK:
            begin
                cok_next = (ram_rdata.time_us >= tmin_reg) &&
                           (ram_rdata.time_us <= tmax_reg) &&
                           (req_reg.cmd != trbq_pkg::CMD_QVOICE ||
                            ram_rdata.voice == req_reg.voice);
                ccand_next.gap = (ram_rdata.time_us >= req_reg.time_us)
                                 ? ram_rdata.time_us - req_reg.time_us
                                 : req_reg.time_us - ram_rdata.time_us;
                ccand_next.idx = ptr_reg;
                ptr_next   = ptr_inc;
                scan_next  = scan_reg + CW'(1);
                state_next = S_QRD;
            end
            S_QORD:
            begin
                ram_raddr = cell_cand[0].idx;
                if (!out_valid_reg)
                begin
                    if (take == '0)
                    begin
                        out_next       = '0;
                        out_next.kind  = trbq_pkg::KIND_NONE;
                        out_next.last  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_QOUT;
                    end
                end
            end
            S_QOUT:
            begin
                out_next               = '0;
                out_next.kind          = trbq_pkg::KIND_ENTRY;
                out_next.entry_time_us = ram_rdata.time_us;
                out_next.entry_voice   = ram_rdata.voice;
                out_next.entry_payload = ram_rdata.payload;
                out_next.last          = (emit_reg + CW'(1) == take);
                out_valid_next         = 1'b1;
                ctl.shl                = 1'b1;
                emit_next              = emit_reg + CW'(1);
                state_next = (emit_reg + CW'(1) == take) ? S_IDLE : S_QORD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= trbq_pkg::DEFAULT_WINDOW;
            cap_reg       <= trbq_pkg::DEFAULT_CAP;
            oldest_reg    <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            scan_reg      <= '0;
            n_reg         <= '0;
            emit_reg      <= '0;
            pruned_reg    <= '0;
            maxo_reg      <= '0;
            cok_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            cap_reg       <= cap_next;
            oldest_reg    <= oldest_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            scan_reg      <= scan_next;
            n_reg         <= n_next;
            emit_reg      <= emit_next;
            pruned_reg    <= pruned_next;
            maxo_reg      <= maxo_next;
            cok_reg       <= cok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ccand_reg <= ccand_next;
        req_reg   <= req_next;
        tmin_reg  <= tmin_next;
        tmax_reg  <= tmax_next;
        out_reg   <= out_next;
    end

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_eff)
        else $error("fill count above capacity");

    a_oldest_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(oldest_reg) < cap_eff)
        else $error("oldest index outside ring");

    a_chain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QORD || state_reg == S_QCHK) && emit_reg == '0
        |-> $countones(cell_valid) == 32'(n_reg))
        else $error("candidate chain out of step with count");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(state_reg) == S_IDLE)
        else $error("item accepted with result pending");

endmodule

### hdl/trbq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/trbq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trbq_cell
// One cell of the sorted candidate chain: insert from the left, drain left.
// ----------------------------------------------------------------------------
module trbq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  trbq_pkg::cell_ctl_t ctl,
    input  trbq_pkg::cand_t    new_cand,
    input  logic               left_keep,
    input  trbq_pkg::cand_t    left_cand,
    input  logic               left_valid,
    input  trbq_pkg::cand_t    right_cand,
    input  logic               right_valid,
    output trbq_pkg::cand_t    cand,
    output logic               valid,
    output logic               keep
);

    trbq_pkg::cand_t cand_reg, cand_next;
    logic            valid_reg, valid_next;

    // equal gaps stay ahead of the newcomer: ties go oldest first
    assign keep  = valid_reg && (cand_reg.gap <= new_cand.gap);
    assign cand  = cand_reg;
    assign valid = valid_reg;

    always_comb
    begin
        cand_next  = cand_reg;
        valid_next = valid_reg;
        priority if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    cand_next  = new_cand;
                    valid_next = 1'b1;
                end
                else
                begin
                    cand_next  = left_cand;
                    valid_next = left_valid;
                end
            end
        end
        else if (ctl.shl)
        begin
            cand_next  = right_cand;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed ring buffer: a local ring model predicts
// push acks and nearest-in-time query results; random traffic and stalls.
// ----------------------------------------------------------------------------
module tb;

    // Scoreboard: holds a model of the ring and the queue of pending results.
    class ring_scoreboard;
        logic [63:0] s_time [trbq_pkg::SLOTS];
        logic [31:0] s_voice [trbq_pkg::SLOTS];
        logic [63:0] s_pay [trbq_pkg::SLOTS];
        int unsigned head;
        int unsigned fill;
        logic [31:0] win;
        logic [5:0]  cap_reg;
        trbq_pkg::out_t pending [$];
        int errors;

        function new();
            head = 0;
            fill = 0;
            win = trbq_pkg::DEFAULT_WINDOW;
            cap_reg = trbq_pkg::DEFAULT_CAP;
            errors = 0;
        endfunction

        function int unsigned cap_eff();
            int unsigned c;
            c = cap_reg;
            if (c == 0) c = 1;
            if (c > trbq_pkg::SLOTS) c = trbq_pkg::SLOTS;
            return c;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == trbq_pkg::REG_WINDOW)
                win = data;
            else
            begin
                cap_reg = data[5:0];
                head = 0;
                fill = 0;
            end
        endfunction

        function trbq_pkg::out_t blank(logic [1:0] k);
            trbq_pkg::out_t r;
            r = '0;
            r.kind = k;
            r.last = 1'b1;
            return r;
        endfunction

        function void queue_result(trbq_pkg::out_t r);
            pending.insert(pending.size(), r);
        endfunction

        function void note_input(trbq_pkg::in_t it);
            int unsigned c;
            int unsigned slot;
            int unsigned pruned;
            logic [31:0] w;
            logic [63:0] t;
            logic [63:0] tmin;
            logic [63:0] tmax;
            logic [63:0] g;
            logic [63:0] gaps [trbq_pkg::SLOTS];
            int unsigned ids [trbq_pkg::SLOTS];
            int unsigned n;
            int unsigned j;
            int unsigned idx;
            int unsigned lim;
            int unsigned take;
            trbq_pkg::out_t r;
            c = cap_eff();
            if (it.cmd == trbq_pkg::CMD_PUSH)
            begin
                w = (win == 0) ? trbq_pkg::DEFAULT_WINDOW : win;
                pruned = 0;
                r = blank(trbq_pkg::KIND_ACK);
                while (fill > 0)
                begin
                    t = s_time[head];
                    if (it.time_us >= t && (it.time_us - t) > {32'd0, w})
                    begin
                        head = (head + 1) % c;
                        fill--;
                        pruned++;
                    end
                    else
                        break;
                end
                if (fill < c)
                begin
                    slot = (head + fill) % c;
                    fill++;
                end
                else
                begin
                    slot = head;
                    head = (head + 1) % c;
                    r.overwrote = 1'b1;
                end
                s_time[slot] = it.time_us;
                s_voice[slot] = it.voice;
                s_pay[slot] = it.payload;
                r.pruned_count = pruned[5:0];
                queue_result(r);
            end
            else if (it.cmd == trbq_pkg::CMD_QTIME || it.cmd == trbq_pkg::CMD_QVOICE)
            begin
                lim = it.max_out;
                if (lim > trbq_pkg::OUT_LIMIT) lim = trbq_pkg::OUT_LIMIT;
                n = 0;
                tmin = (it.time_us > it.lookback_us) ? it.time_us - it.lookback_us : 64'd0;
                tmax = (it.time_us > 64'hFFFF_FFFF_FFFF_FFFF - it.lookahead_us)
                    ? 64'hFFFF_FFFF_FFFF_FFFF : it.time_us + it.lookahead_us;
                if (lim != 0)
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        idx = (head + i) % c;
                        t = s_time[idx];
                        if (it.cmd == trbq_pkg::CMD_QVOICE && s_voice[idx] != it.voice)
                            continue;
                        if (t < tmin || t > tmax) continue;
                        g = (t >= it.time_us) ? t - it.time_us : it.time_us - t;
                        j = n;
                        while (j > 0 && gaps[j-1] > g)
                        begin
                            gaps[j] = gaps[j-1];
                            ids[j] = ids[j-1];
                            j--;
                        end
                        gaps[j] = g;
                        ids[j] = idx;
                        n++;
                    end
                end
                if (n == 0)
                    queue_result(blank(trbq_pkg::KIND_NONE));
                else
                begin
                    take = (n < lim) ? n : lim;
                    for (int i = 0; i < take; i++)
                    begin
                        r = '0;
                        r.kind = trbq_pkg::KIND_ENTRY;
                        r.entry_time_us = s_time[ids[i]];
                        r.entry_voice = s_voice[ids[i]];
                        r.entry_payload = s_pay[ids[i]];
                        r.last = (i + 1 == take);
                        queue_result(r);
                    end
                end
            end
        endfunction

        function void check_result(trbq_pkg::out_t got);
            trbq_pkg::out_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result mismatch exp: kind=%0d t=%h v=%h p=%h ow=%b pr=%0d last=%b",
                        exp_r.kind, exp_r.entry_time_us, exp_r.entry_voice,
                        exp_r.entry_payload, exp_r.overwrote, exp_r.pruned_count,
                        exp_r.last);
                    $display("                got: kind=%0d t=%h v=%h p=%h ow=%b pr=%0d last=%b",
                        got.kind, got.entry_time_us, got.entry_voice,
                        got.entry_payload, got.overwrote, got.pruned_count, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    trbq_pkg::in_t  in_item;
    logic out_valid;
    logic out_stall;
    trbq_pkg::out_t out_item;
    logic cfg_we;
    logic cfg_index;
    logic [31:0] cfg_data;

    ring_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int quiet_cycles;
    logic [63:0] base_t;

    timed_ring_buffer_nearest_query dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Watchdog on cycles with no item moving either way.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Valid stays high into the next item when there is no idle gap.
    task automatic send_item(trbq_pkg::in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic trbq_pkg::in_t mk_push(logic [63:0] t, logic [31:0] v,
                                              logic [63:0] p);
        trbq_pkg::in_t it;
        it = '0;
        it.cmd = trbq_pkg::CMD_PUSH;
        it.time_us = t;
        it.voice = v;
        it.payload = p;
        return it;
    endfunction

    function automatic trbq_pkg::in_t mk_query(logic [1:0] c, logic [63:0] t,
                                               logic [31:0] v, logic [31:0] lb,
                                               logic [31:0] la, logic [5:0] m);
        trbq_pkg::in_t it;
        it = '0;
        it.cmd = c;
        it.time_us = t;
        it.voice = v;
        it.lookback_us = lb;
        it.lookahead_us = la;
        it.max_out = m;
        it.payload = {$urandom, $urandom};
        return it;
    endfunction

    // Mostly well-formed traffic around a moving clock, small voice set.
    task automatic random_items(int count);
        trbq_pkg::in_t it;
        logic [255:0] raw;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            base_t = base_t + $urandom_range(60000);
            if (sel < 50)
                it = mk_push(base_t - $urandom_range(20000), $urandom_range(3),
                             {$urandom, $urandom});
            else if (sel < 90)
                it = mk_query(($urandom_range(1)) ? trbq_pkg::CMD_QTIME
                                                  : trbq_pkg::CMD_QVOICE,
                              base_t - $urandom_range(100000), $urandom_range(3),
                              $urandom_range(400000), $urandom_range(400000),
                              $urandom_range(40));
            else
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom};
                it = raw[$bits(trbq_pkg::in_t)-1:0];
                if (it.cmd == 2'd3 && $urandom_range(1)) it.cmd = trbq_pkg::CMD_PUSH;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = trbq_pkg::REG_WINDOW;
        cfg_data = '0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        base_t = 64'd1000000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of fields, each command, empty and unused cases.
        send_item(mk_query(trbq_pkg::CMD_QTIME, 64'd5, 32'd0, 32'd10, 32'd10, 6'd5));
        send_item(mk_push(64'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(mk_push(64'd100, 32'd1, 64'd0));
        send_item(mk_push(64'd90, 32'd1, 64'h1234));
        send_item(mk_push(64'd110, 32'd2, 64'h5678));
        send_item(mk_query(trbq_pkg::CMD_QTIME, 64'd100, 32'd0, 32'hFFFF_FFFF, 32'd10,
                           6'd63));
        send_item(mk_query(trbq_pkg::CMD_QVOICE, 64'd100, 32'd1, 32'd50, 32'd50, 6'd1));
        send_item(mk_query(trbq_pkg::CMD_QTIME, 64'd100, 32'd0, 32'd50, 32'd50, 6'd0));
        send_item(mk_query(trbq_pkg::CMD_QTIME, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 32'd0,
                           32'hFFFF_FFFF, 6'd32));
        send_item(mk_query(trbq_pkg::CMD_QVOICE, 64'd0, 32'hFFFF_FFFF, 32'd5, 32'd0,
                           6'd32));
        begin
            trbq_pkg::in_t junk;
            junk = mk_push(64'd7, 32'd7, 64'd7);
            junk.cmd = 2'd3;
            send_item(junk);
        end
        send_item(mk_push(64'd400000, 32'd3, 64'd9));
        send_item(mk_push(64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 64'd10));
        send_item(mk_push(64'd400001, 32'd3, 64'd11));
        send_item(mk_query(trbq_pkg::CMD_QTIME, 64'd400000, 32'd0, 32'd1, 32'd1, 6'd32));

        // Capacity and window sweeps, extremes included.
        write_cfg(trbq_pkg::REG_CAP, 32'd0);
        write_cfg(trbq_pkg::REG_WINDOW, 32'd0);
        base_t = 64'd1000000;
        random_items(20);
        write_cfg(trbq_pkg::REG_CAP, 32'd63);
        write_cfg(trbq_pkg::REG_WINDOW, 32'd1);
        random_items(20);
        write_cfg(trbq_pkg::REG_WINDOW, 32'hFFFF_FFFF);
        write_cfg(trbq_pkg::REG_CAP, 32'd4);
        random_items(30);

        write_cfg(trbq_pkg::REG_CAP, 32'd32);
        write_cfg(trbq_pkg::REG_WINDOW, 32'd350000);
        random_items(60);
        send_idle_pct = 70;
        random_items(50);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        random_items(50);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        random_items(50);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Long receiver hold-off while items keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_items(30);
        join
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
